// ----- design/mirs_pkg.sv -----
// Shared constants, codes and handshake structs of the material id remap search.
`default_nettype none

package mirs_pkg;

  localparam int MAX_INSTANCES = 1024;
  localparam int MAX_LISTS     = 256;
  localparam int MAX_PAIRS     = 4096;

  // Field widths fixed by the item format
  localparam int OP_W       = 2;
  localparam int INST_W     = 10;
  localparam int LIST_W     = 9;
  localparam int OFFSET_W   = 14;
  localparam int PAIR_IDX_W = 12;
  localparam int ID_W       = 32;

  localparam int INST_AW  = $clog2(MAX_INSTANCES);
  localparam int PAIR_AW  = $clog2(MAX_PAIRS);
  localparam int WADDR_W  = OFFSET_W + 1;   // start + 2 * pair number
  localparam int CNT_W    = OFFSET_W - 1;   // half a word difference
  localparam int PAIR_W   = 2 * ID_W;

  localparam logic [LIST_W-1:0]   LIST_LIMIT = LIST_W'(MAX_LISTS);
  localparam logic [PAIR_IDX_W:0] PAIR_LIMIT = (PAIR_IDX_W + 1)'(MAX_PAIRS);
  localparam logic [WADDR_W-2:0]  WORD_PAIR_LIMIT = (WADDR_W - 1)'(MAX_PAIRS);

  typedef enum logic [OP_W-1:0] {
    OP_MAP_WR   = 2'd0,
    OP_START_WR = 2'd1,
    OP_PAIR_WR  = 2'd2,
    OP_LOOKUP   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_START,
    ST_NEXT,
    ST_PROBE,
    ST_SEARCH,
    ST_CHK,
    ST_TO,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic ld_list;
    logic ld_start;
    logic ld_count;
    logic probe;
    logic step;
    logic rd_next;
    logic res_pass;
    logic res_word;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic list_none;
    logic empty;
    logic more;
    logic found_ok;
    logic match;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/material_id_remap_search.sv -----
// Top level of the material id remap search: sequencer plus datapath.
//
// Write items load three tables (instance map, list starts, pair store) and
// give no result. A lookup item reads the instance's list number, then the
// list's start and the next list's start, and runs a lower-bound binary search
// over the list's (from, to) pairs, one probe per cycle through the single
// read port of the pair store. A lookup ends early when the instance has no
// list or the list is empty; otherwise it makes at most ceil(log2(pairs + 1))
// probes, then checks the from-id found and, for a match, reads its to-id;
// the largest list holds 8191 pairs. A new result waits in the done state
// while the previous one is still stalled at the output. The result waits in
// an output register, so a new item is taken while the previous result is
// still stalled. Tables are not cleared at reset: read only entries that have
// been written.
`default_nettype none

module material_id_remap_search
  import mirs_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [OP_W-1:0]          op_i,
  input  wire logic [INST_W-1:0]        instance_id_i,
  input  wire logic signed [LIST_W-1:0] list_ref_i,
  input  wire logic [LIST_W-1:0]        list_index_i,
  input  wire logic [OFFSET_W-1:0]      word_offset_i,
  input  wire logic [PAIR_IDX_W-1:0]    pair_index_i,
  input  wire logic [ID_W-1:0]          remap_from_i,
  input  wire logic [ID_W-1:0]          remap_to_i,
  input  wire logic [ID_W-1:0]          material_id_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [ID_W-1:0]               material_out_o,
  output logic                          was_remapped_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: accept, step through table reads and probes, hand over the item
  mirs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .op_i        (op_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: tables, search bounds and result registers
  mirs_dpath u_dpath (
    .clk_i          (clk_i),
    .op_i           (op_i),
    .instance_id_i  (instance_id_i),
    .list_ref_i     (list_ref_i),
    .list_index_i   (list_index_i),
    .word_offset_i  (word_offset_i),
    .pair_index_i   (pair_index_i),
    .remap_from_i   (remap_from_i),
    .remap_to_i     (remap_to_i),
    .material_id_i  (material_id_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .material_out_o (material_out_o),
    .was_remapped_o (was_remapped_o)
  );

endmodule

`default_nettype wire

// ----- design/mirs_ctrl.sv -----
// Sequencer of the material id remap search: one item at a time, output handshake.
`default_nettype none

module mirs_ctrl
  import mirs_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [OP_W-1:0] op_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire sts_t            sts_i,
  output cmd_t                 cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign in_stall_o  = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (op_e'(op_i) == OP_LOOKUP) state_d = ST_MAP;
        end
      end
      ST_MAP: begin
        if (sts_i.list_none) begin
          cmd_o.res_pass = 1'b1;
          state_d        = ST_DONE;
        end else begin
          cmd_o.ld_list = 1'b1;
          state_d       = ST_START;
        end
      end
      ST_START: begin
        cmd_o.ld_start = 1'b1;
        state_d        = ST_NEXT;
      end
      ST_NEXT: begin
        cmd_o.ld_count = 1'b1;
        if (sts_i.empty) begin
          cmd_o.res_pass = 1'b1;
          state_d        = ST_DONE;
        end else begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        cmd_o.probe = 1'b1;
        state_d     = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd_o.step = 1'b1;
        if (!sts_i.more) begin
          if (sts_i.found_ok) begin
            state_d = ST_CHK;
          end else begin
            cmd_o.res_pass = 1'b1;
            state_d        = ST_DONE;
          end
        end
      end
      ST_CHK: begin
        if (sts_i.match) begin
          cmd_o.rd_next = 1'b1;
          state_d       = ST_TO;
        end else begin
          cmd_o.res_pass = 1'b1;
          state_d        = ST_DONE;
        end
      end
      ST_TO: begin
        cmd_o.res_word = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- design/mirs_dpath.sv -----
// Tables, search registers and result registers of the material id remap search.
`default_nettype none

module mirs_dpath
  import mirs_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic [OP_W-1:0]        op_i,
  input  wire logic [INST_W-1:0]      instance_id_i,
  input  wire logic signed [LIST_W-1:0] list_ref_i,
  input  wire logic [LIST_W-1:0]      list_index_i,
  input  wire logic [OFFSET_W-1:0]    word_offset_i,
  input  wire logic [PAIR_IDX_W-1:0]  pair_index_i,
  input  wire logic [ID_W-1:0]        remap_from_i,
  input  wire logic [ID_W-1:0]        remap_to_i,
  input  wire logic [ID_W-1:0]        material_id_i,
  input  wire cmd_t                   cmd_i,
  output sts_t                        sts_o,
  output logic [ID_W-1:0]             material_out_o,
  output logic                        was_remapped_o
);

  function automatic logic [WADDR_W-1:0] word_addr(input logic [OFFSET_W-1:0] start,
                                                   input logic [CNT_W-1:0]    pair);
    word_addr = {1'b0, start} + {1'b0, pair, 1'b0};
  endfunction

  // Stores
  logic [LIST_W-1:0]   map_mem   [MAX_INSTANCES];
  logic [OFFSET_W-1:0] start_mem [MAX_LISTS + 1];
  logic [PAIR_W-1:0]   pair_mem  [MAX_PAIRS];

  logic [LIST_W-1:0]   map_rd_q;
  logic [OFFSET_W-1:0] start_rd_q;
  logic [PAIR_W-1:0]   pair_rd_q;
  logic                sel_q, beyond_q;

  logic [LIST_W-1:0]   list_q;
  logic [OFFSET_W-1:0] start_q;
  logic [CNT_W-1:0]    count_q, lo_q, hix_q, m_q;
  logic [WADDR_W-1:0]  addr_q;
  logic [ID_W-1:0]     mat_q, res_q, out_q;
  logic                hit_q, was_q;

  logic                op_map, op_start, op_pair;
  logic [LIST_W-1:0]   start_raddr;
  logic                start_ren, pair_ren;
  logic [OFFSET_W:0]   diff;
  logic [CNT_W-1:0]    count_d;
  logic [CNT_W-1:0]    span, m_probe, m1, m_a, m_b, m_next, hi_next;
  logic                cont_a, cont_b, ge;
  logic [WADDR_W-1:0]  addr_a, addr_b, addr_hix, step_addr, pair_raddr;
  logic [ID_W-1:0]     word;

  assign op_map   = cmd_i.accept && (op_e'(op_i) == OP_MAP_WR);
  assign op_start = cmd_i.accept && (op_e'(op_i) == OP_START_WR) && (list_index_i <= LIST_LIMIT);
  assign op_pair  = cmd_i.accept && (op_e'(op_i) == OP_PAIR_WR)
                    && ({1'b0, pair_index_i} < PAIR_LIMIT);

  // Instance map: read on every accepted item, write on a map write
  always_ff @(posedge clk_i) begin
    if (op_map) map_mem[instance_id_i[INST_AW-1:0]] <= list_ref_i;
    if (cmd_i.accept) map_rd_q <= map_mem[instance_id_i[INST_AW-1:0]];
  end

  // List starts: this list, then the next one
  assign start_raddr = cmd_i.ld_list ? map_rd_q : list_q + 1'b1;
  assign start_ren   = cmd_i.ld_list || cmd_i.ld_start;

  always_ff @(posedge clk_i) begin
    if (op_start) start_mem[list_index_i] <= word_offset_i;
    if (start_ren) start_rd_q <= start_mem[start_raddr];
  end

  // Pair count from the two starts; empty when not positive
  assign diff    = {1'b0, start_rd_q} - {1'b0, start_q};
  assign count_d = diff[OFFSET_W-1:1];

  // Word read of the pair store
  assign word = beyond_q ? '0 : (sel_q ? pair_rd_q[PAIR_W-1:ID_W] : pair_rd_q[ID_W-1:0]);
  assign ge   = (word >= mat_q);

  // Both outcomes of a probe prepared alongside the compare
  assign span    = hix_q - lo_q - 1'b1;
  assign m_probe = lo_q + (span >> 1);
  assign m1      = m_q + 1'b1;
  assign cont_a  = (lo_q < m_q);
  assign cont_b  = (m1 < hix_q);
  assign m_a     = lo_q + ((m_q - lo_q - 1'b1) >> 1);
  assign m_b     = m1 + ((hix_q - m1 - 1'b1) >> 1);
  assign addr_a  = word_addr(start_q, m_a);
  assign addr_b  = word_addr(start_q, m_b);
  assign addr_hix = word_addr(start_q, hix_q);

  assign m_next  = ge ? m_a : m_b;
  assign hi_next = ge ? m_q : hix_q;

  always_comb begin
    if (ge) begin
      step_addr = cont_a ? addr_a : addr_q;
    end else begin
      step_addr = cont_b ? addr_b : addr_hix;
    end
  end

  always_comb begin
    if (cmd_i.probe) begin
      pair_raddr = word_addr(start_q, m_probe);
    end else if (cmd_i.step) begin
      pair_raddr = step_addr;
    end else begin
      pair_raddr = addr_q + 1'b1;
    end
  end

  assign pair_ren = cmd_i.probe || cmd_i.step || cmd_i.rd_next;

  always_ff @(posedge clk_i) begin
    if (op_pair) pair_mem[pair_index_i[PAIR_AW-1:0]] <= {remap_to_i, remap_from_i};
    if (pair_ren) begin
      pair_rd_q <= pair_mem[pair_raddr[PAIR_AW:1]];
      sel_q     <= pair_raddr[0];
      beyond_q  <= (pair_raddr[WADDR_W-1:1] >= WORD_PAIR_LIMIT);
    end
  end

  // Search registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) mat_q <= material_id_i;
    if (cmd_i.ld_list) list_q <= map_rd_q;
    if (cmd_i.ld_start) start_q <= start_rd_q;
    if (cmd_i.ld_count) begin
      count_q <= count_d;
      lo_q    <= '0;
      hix_q   <= count_d;
    end
    if (cmd_i.probe) begin
      m_q    <= m_probe;
      addr_q <= pair_raddr;
    end
    if (cmd_i.step) begin
      m_q    <= m_next;
      addr_q <= pair_raddr;
      if (ge) begin
        hix_q <= m_q;
      end else begin
        lo_q <= m1;
      end
    end
    if (cmd_i.res_pass) begin
      res_q <= mat_q;
      hit_q <= 1'b0;
    end
    if (cmd_i.res_word) begin
      res_q <= word;
      hit_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
      was_q <= hit_q;
    end
  end

  // A span of one word holds no whole pair
  assign sts_o.list_none = !(map_rd_q < LIST_LIMIT);
  assign sts_o.empty     = diff[OFFSET_W] || (count_d == '0);
  assign sts_o.more      = ge ? cont_a : cont_b;
  assign sts_o.found_ok  = (hi_next < count_q);
  assign sts_o.match     = (word == mat_q);

  assign material_out_o = out_q;
  assign was_remapped_o = was_q;

endmodule

`default_nettype wire

// ----- design/mirs_checker.sv -----
// Port-level checks of the material id remap search, bound to the top level.
`default_nettype none

module mirs_checker
  import mirs_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_stall_o,
  input wire logic [OP_W-1:0] op_i,
  input wire logic            out_valid_o,
  input wire logic            out_stall_i,
  input wire logic [ID_W-1:0] material_out_o,
  input wire logic            was_remapped_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // Hold a stalled item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(material_out_o)
                                   && $stable(was_remapped_o))
    else $error("stalled result item changed");

  // A lookup occupies the block for at least the next cycle
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (op_e'(op_i) == OP_LOOKUP) |=> in_stall_o)
    else $error("lookup item did not occupy the block");

  // A write item finishes at once
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (op_e'(op_i) != OP_LOOKUP) |=> !in_stall_o)
    else $error("write item stalled the input");

  // A write item never produces a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (op_e'(op_i) != OP_LOOKUP) |=> !$rose(out_valid_o))
    else $error("write item produced a result");

endmodule

bind material_id_remap_search mirs_checker u_mirs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .op_i           (op_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .material_out_o (material_out_o),
  .was_remapped_o (was_remapped_o)
);

`default_nettype wire
